FILE: hdl/rhsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rhsv_pkg;

	localparam int COMP_W    = 16;
	localparam int HUE_W     = 15;
	localparam int NUM_W     = 2 * COMP_W;
	// one quotient bit per divider stage
	localparam int DIV_STEPS = COMP_W;

	// hue in 1/64 degree: one 60 degree sector is 3840, full circle 23040
	localparam logic [HUE_W-1:0] HUE_BASE_G = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BASE_B = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_CIRCLE = 15'd23040;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic              hue_undefined;
		logic [COMP_W-1:0] saturation;
		logic [COMP_W-1:0] brightness;
	} hsv_t;

	// fields that ride alongside the divisions
	typedef struct packed {
		logic              undef;
		logic [COMP_W-1:0] bright;
		sector_t           sec;
		logic              neg;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0]  sat_num;
		logic [COMP_W-1:0] sat_den;
		logic [NUM_W-1:0]  hue_num;
		logic [COMP_W-1:0] hue_den;
		side_t             side;
	} div_req_t;

	typedef struct packed {
		logic [COMP_W-1:0] sat_quo;
		logic [COMP_W-1:0] hue_quo;
		logic [COMP_W-1:0] hue_rem;
		side_t             side;
	} div_rsp_t;

	// partial state of one restoring division
	typedef struct packed {
		logic [COMP_W-1:0] rem;
		logic [COMP_W-1:0] low;
		logic [COMP_W-1:0] quo;
		logic [COMP_W-1:0] den;
	} lane_t;

endpackage
`default_nettype wire

FILE: hdl/rhsv_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rhsv_front import rhsv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_vld,
	input  wire pixel_t   pix,
	output logic          out_vld,
	output div_req_t      req
);

	logic              vld_s1;
	pixel_t            pix_s1;

	logic              vld_s2;
	logic [COMP_W-1:0] max_s2;
	logic [COMP_W-1:0] delta_s2;
	logic [COMP_W-1:0] adiff_s2;
	sector_t           sec_s2;
	logic              neg_s2;

	logic              vld_s3;
	div_req_t          req_s3;

	logic              red_max;
	logic              green_max;
	logic [COMP_W-1:0] mx;
	logic [COMP_W-1:0] mn;
	logic [COMP_W:0]   diff;
	sector_t           sec;
	div_req_t          req_c;

	// stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pix;
	end

	// stage 2: max, min, sector, signed difference
	always_comb begin
		red_max   = (pix_s1.red >= pix_s1.green) && (pix_s1.red >= pix_s1.blue);
		green_max = !red_max && (pix_s1.green >= pix_s1.blue);
		if (red_max) begin
			mx   = pix_s1.red;
			sec  = SEC_RED;
			diff = {1'b0, pix_s1.green} - {1'b0, pix_s1.blue};
		end else if (green_max) begin
			mx   = pix_s1.green;
			sec  = SEC_GREEN;
			diff = {1'b0, pix_s1.blue} - {1'b0, pix_s1.red};
		end else begin
			mx   = pix_s1.blue;
			sec  = SEC_BLUE;
			diff = {1'b0, pix_s1.red} - {1'b0, pix_s1.green};
		end
		mn = (pix_s1.red < pix_s1.green) ? pix_s1.red : pix_s1.green;
		if (pix_s1.blue < mn) begin
			mn = pix_s1.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		max_s2   <= mx;
		delta_s2 <= mx - mn;
		sec_s2   <= sec;
		neg_s2   <= diff[COMP_W];
		adiff_s2 <= diff[COMP_W] ? (~diff[COMP_W-1:0] + 1'b1) : diff[COMP_W-1:0];
	end

	// stage 3: numerators by shift and subtract
	// 65535*delta = delta<<16 - delta, 3840*|diff| = |diff|<<12 - |diff|<<8
	always_comb begin
		req_c.sat_num     = {delta_s2, {COMP_W{1'b0}}} - {{COMP_W{1'b0}}, delta_s2};
		req_c.sat_den     = max_s2;
		req_c.hue_num     = {4'b0, adiff_s2, 12'b0} - {8'b0, adiff_s2, 8'b0};
		req_c.hue_den     = delta_s2;
		// max zero implies delta zero
		req_c.side.undef  = (delta_s2 == '0);
		req_c.side.bright = max_s2;
		req_c.side.sec    = sec_s2;
		req_c.side.neg    = neg_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		req_s3 <= req_c;
	end

	assign out_vld = vld_s3;
	assign req     = req_s3;

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (req_s3.hue_num[NUM_W-1:COMP_W] < req_s3.hue_den) || req_s3.side.undef)
		else $error("hue numerator would overflow the quotient");

endmodule
`default_nettype wire

FILE: hdl/rhsv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rhsv_div import rhsv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_vld,
	input  wire div_req_t req,
	output logic          out_vld,
	output div_rsp_t      rsp
);

	// two restoring dividers side by side, one quotient bit per stage
	function automatic lane_t div_step(input lane_t l);
		logic [COMP_W:0] t;
		logic [COMP_W:0] d;
		lane_t           n;
		t = {l.rem, l.low[COMP_W-1]};
		d = {1'b0, l.den};
		n = l;
		n.low = {l.low[COMP_W-2:0], 1'b0};
		if (t >= d) begin
			n.rem = COMP_W'(t - d);
			n.quo = {l.quo[COMP_W-2:0], 1'b1};
		end else begin
			n.rem = t[COMP_W-1:0];
			n.quo = {l.quo[COMP_W-2:0], 1'b0};
		end
		return n;
	endfunction

	lane_t sat_sn  [DIV_STEPS];
	lane_t hue_sn  [DIV_STEPS];
	side_t side_sn [DIV_STEPS];
	logic  vld_sn  [DIV_STEPS];

	lane_t sat_in  [DIV_STEPS];
	lane_t hue_in  [DIV_STEPS];
	side_t side_in [DIV_STEPS];
	logic  vld_in  [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		if (k == 0) begin : g_head
			assign sat_in[k]  = '{rem: req.sat_num[NUM_W-1:COMP_W],
				low: req.sat_num[COMP_W-1:0], quo: '0, den: req.sat_den};
			assign hue_in[k]  = '{rem: req.hue_num[NUM_W-1:COMP_W],
				low: req.hue_num[COMP_W-1:0], quo: '0, den: req.hue_den};
			assign side_in[k] = req.side;
			assign vld_in[k]  = in_vld;
		end else begin : g_link
			assign sat_in[k]  = sat_sn[k-1];
			assign hue_in[k]  = hue_sn[k-1];
			assign side_in[k] = side_sn[k-1];
			assign vld_in[k]  = vld_sn[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= vld_in[k];
			end
		end

		always_ff @(posedge clk) begin
			sat_sn[k]  <= div_step(sat_in[k]);
			hue_sn[k]  <= div_step(hue_in[k]);
			side_sn[k] <= side_in[k];
		end
	end

	assign out_vld     = vld_sn[DIV_STEPS-1];
	assign rsp.sat_quo = sat_sn[DIV_STEPS-1].quo;
	assign rsp.hue_quo = hue_sn[DIV_STEPS-1].quo;
	assign rsp.hue_rem = hue_sn[DIV_STEPS-1].rem;
	assign rsp.side    = side_sn[DIV_STEPS-1];

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[DIV_STEPS-1] && (hue_sn[DIV_STEPS-1].den != '0)
		|-> hue_sn[DIV_STEPS-1].rem < hue_sn[DIV_STEPS-1].den)
		else $error("hue remainder not below divisor");

endmodule
`default_nettype wire

FILE: hdl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSV (hexcone) converter. One pixel request is taken on every clock
// edge at which start is high; busy is never raised, so a pixel may be sent
// in every cycle. Each request gives one result on hsv, marked by a one-cycle
// done strobe, in request order. The receiver cannot stall and must take each
// result as it appears. A result passes through three front stages, the two
// 16-stage restoring dividers (one quotient bit per stage) and the output
// register. Hue is in 1/64 degree (0..23039); for a black or grey pixel
// hue_undefined is set and hue and saturation read 0. Brightness is the
// largest component.
module rgb_to_hsv_converter import rhsv_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire pixel_t pixel,
	output logic        done,
	output hsv_t        hsv
);

	logic          front_vld;
	div_req_t      div_req;
	logic          div_vld;
	div_rsp_t      div_rsp;

	logic [HUE_W-1:0] q;
	logic             rem_nz;
	hsv_t             hsv_c;

	logic             done_q;
	hsv_t             hsv_q;

	// fully pipelined, nothing ever backs up
	assign busy = 1'b0;

	// stages 1 to 3: extremes, sector, numerators
	rhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.pix     (pixel),
		.out_vld (front_vld),
		.req     (div_req)
	);

	// stages 4 to 19: saturation and hue quotients
	rhsv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (front_vld),
		.req     (div_req),
		.out_vld (div_vld),
		.rsp     (div_rsp)
	);

	// Stage 20: place the hue in its sector.
	// Red sector truncates toward zero and wraps a negative result;
	// green and blue sit on a positive base, so a negative difference
	// rounds the quotient up before it is taken off.
	always_comb begin
		q      = div_rsp.hue_quo[HUE_W-1:0];
		rem_nz = (div_rsp.hue_rem != '0);
		hsv_c.brightness    = div_rsp.side.bright;
		hsv_c.hue_undefined = div_rsp.side.undef;
		hsv_c.saturation    = div_rsp.side.undef ? '0 : div_rsp.sat_quo;
		case (div_rsp.side.sec)
			SEC_RED: begin
				if (!div_rsp.side.neg) begin
					hsv_c.hue = q;
				end else if (q == '0) begin
					hsv_c.hue = '0;
				end else begin
					hsv_c.hue = HUE_CIRCLE - q;
				end
			end
			SEC_GREEN: begin
				if (div_rsp.side.neg) begin
					hsv_c.hue = HUE_BASE_G - q - HUE_W'(rem_nz);
				end else begin
					hsv_c.hue = HUE_BASE_G + q;
				end
			end
			SEC_BLUE: begin
				if (div_rsp.side.neg) begin
					hsv_c.hue = HUE_BASE_B - q - HUE_W'(rem_nz);
				end else begin
					hsv_c.hue = HUE_BASE_B + q;
				end
			end
			default: begin
				hsv_c.hue = '0;
			end
		endcase
		if (div_rsp.side.undef) begin
			hsv_c.hue = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		hsv_q <= hsv_c;
	end

	assign done = done_q;
	assign hsv  = hsv_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hsv.hue < HUE_CIRCLE)
		else $error("hue out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && hsv.hue_undefined |-> (hsv.hue == '0) && (hsv.saturation == '0))
		else $error("undefined hue with nonzero hue or saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && !hsv.hue_undefined |-> (hsv.saturation != '0) && (hsv.brightness != '0))
		else $error("coloured pixel with zero saturation or value");

endmodule
`default_nettype wire
